>>> hw/rtl/mono_raster_draw_engine_macros.svh
// Assertion macros used by the draw engine checker.
`ifndef MONO_RASTER_DRAW_ENGINE_MACROS_SVH
`define MONO_RASTER_DRAW_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MRDE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MRDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mrde_pkg.sv
// Shared types, command codes and helpers of the draw engine.
package mrde_pkg;

    localparam int ROW_W     = 32;
    localparam int COORD_W   = 5;
    localparam int ADDR_ROWS = 32;

    localparam logic [ROW_W-1:0]   ALL_ONES = '1;
    localparam logic [COORD_W-1:0] COL_MAX  = 5'd31;

    localparam logic [2:0] OP_CLEAR   = 3'd0;
    localparam logic [2:0] OP_PIXEL   = 3'd1;
    localparam logic [2:0] OP_HLINE   = 3'd2;
    localparam logic [2:0] OP_VLINE   = 3'd3;
    localparam logic [2:0] OP_RECT    = 3'd4;
    localparam logic [2:0] OP_OUTLINE = 3'd5;
    localparam logic [2:0] OP_FLUSH   = 3'd6;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_PAINT,
        ST_FLUSH
    } state_t;

    // Columns a..b inclusive, column 0 in the MSB.
    function automatic logic [ROW_W-1:0] span_mask(logic [COORD_W-1:0] a,
                                                   logic [COORD_W-1:0] b);
        return (ALL_ONES >> a) & (ALL_ONES << (COL_MAX - b));
    endfunction

endpackage

>>> hw/rtl/mrde_cmd_if.sv
// Command request channel of the draw engine.
interface mrde_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [4:0] x_first;
    logic [4:0] y_first;
    logic [4:0] x_second;
    logic [4:0] y_second;
    logic       pen_color;

    modport source (
        output valid, opcode, x_first, y_first, x_second, y_second, pen_color,
        input  ready
    );
    modport sink (
        input  valid, opcode, x_first, y_first, x_second, y_second, pen_color,
        output ready
    );
endinterface

>>> hw/rtl/mrde_row_if.sv
// Flushed row request channel of the draw engine.
interface mrde_row_if;
    logic        valid;
    logic        ready;
    logic [4:0]  row_index;
    logic [31:0] row_pixels;
    logic        last_row;

    modport source (
        output valid, row_index, row_pixels, last_row,
        input  ready
    );
    modport sink (
        input  valid, row_index, row_pixels, last_row,
        output ready
    );
endinterface

>>> hw/rtl/mrde_row_mem.sv
// Frame store: one write port, one registered read port.
module mrde_row_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [mrde_pkg::ROW_W-1:0]   wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [mrde_pkg::ROW_W-1:0]   rd_data
);

    logic [mrde_pkg::ROW_W-1:0] mem [DEPTH];
    logic [mrde_pkg::ROW_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/mono_raster_draw_engine.sv
// Top level of the monochrome draw engine.
// The frame store holds min(ROWS, 32) rows of 32 one-bit pixels in one memory with a
// registered read; rows at or above 32 cannot be addressed, so they are not stored.
// After reset the block clears the store with cmd.ready low. Clear then writes one
// row per cycle over all min(ROWS, 32) rows. Pixel and horizontal line take one
// read-modify-write row, vertical line and rectangles one row per cycle over the rows
// spanned; the last row's write-back overlaps the accept cycle of the next command.
// Flush reads one dirty row per cycle through the memory read port; a row passes the
// read stage and then the output register before it reaches the output, and the stream
// keeps one row per cycle while row.ready stays high. A flush with no dirty row emits
// nothing and returns at once. Painting pauses while a flushed row still occupies the
// read stage.
module mono_raster_draw_engine #(
    parameter int ROWS = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    mrde_cmd_if.sink cmd,
    mrde_row_if.source row
);

    localparam int DEPTH = (ROWS < mrde_pkg::ADDR_ROWS) ? ROWS : mrde_pkg::ADDR_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [4:0]    TOP_ROW   = 5'(DEPTH - 1);
    localparam logic [AW-1:0] FILL_LAST = AW'(DEPTH - 1);

    mrde_pkg::state_t state_reg, state_next;

    logic [AW-1:0]               fill_cnt_reg;
    logic                        fill_pen_reg;
    logic [4:0]                  row_cnt_reg;
    logic [4:0]                  row_end_reg;
    logic [4:0]                  yl_reg;
    logic [4:0]                  yh_reg;
    logic [mrde_pkg::ROW_W-1:0]  mask_mid_reg;
    logic [mrde_pkg::ROW_W-1:0]  mask_end_reg;
    logic                        pen_reg;
    logic                        wb_valid_reg;
    logic [4:0]                  wb_row_reg;
    logic [4:0]                  fl_cnt_reg;
    logic [4:0]                  fl_end_reg;
    logic                        fp_valid_reg;
    logic [4:0]                  fp_row_reg;
    logic                        fp_last_reg;
    logic                        out_valid_reg;
    logic [4:0]                  out_index_reg;
    logic                        out_last_reg;
    logic [mrde_pkg::ROW_W-1:0]  out_pixels_reg;
    logic                        dirty_any_reg;
    logic [4:0]                  dirty_first_reg;
    logic [4:0]                  dirty_last_reg;

    logic                        cmd_fire;
    logic [4:0]                  xl, xh, yl, yh;
    logic                        dec_paint;
    logic [4:0]                  dec_lo, dec_hi, dec_hi_clip;
    logic [mrde_pkg::ROW_W-1:0]  dec_mid, dec_end;
    logic                        dec_in;
    logic                        widen;
    logic [4:0]                  widen_lo, widen_hi;

    logic                        fill_wr;
    logic                        paint_rd;
    logic                        fl_issue;
    logic                        fp_adv;
    logic                        mem_wr_en;
    logic [AW-1:0]               mem_wr_addr;
    logic [mrde_pkg::ROW_W-1:0]  mem_wr_data;
    logic                        mem_rd_en;
    logic [AW-1:0]               mem_rd_addr;
    logic [mrde_pkg::ROW_W-1:0]  mem_rd_data;
    logic [mrde_pkg::ROW_W-1:0]  wb_mask;

    assign cmd_fire = cmd.valid && cmd.ready;

    // Command decode
    always_comb
    begin
        xl = (cmd.x_first < cmd.x_second) ? cmd.x_first : cmd.x_second;
        xh = (cmd.x_first < cmd.x_second) ? cmd.x_second : cmd.x_first;
        yl = (cmd.y_first < cmd.y_second) ? cmd.y_first : cmd.y_second;
        yh = (cmd.y_first < cmd.y_second) ? cmd.y_second : cmd.y_first;
        dec_paint = 1'b1;
        dec_lo    = yl;
        dec_hi    = yh;
        dec_mid   = mrde_pkg::span_mask(xl, xh);
        dec_end   = mrde_pkg::span_mask(xl, xh);
        unique case (cmd.opcode)
            mrde_pkg::OP_PIXEL:
            begin
                dec_lo  = cmd.y_first;
                dec_hi  = cmd.y_first;
                dec_mid = mrde_pkg::span_mask(cmd.x_first, cmd.x_first);
                dec_end = mrde_pkg::span_mask(cmd.x_first, cmd.x_first);
            end
            mrde_pkg::OP_HLINE:
            begin
                dec_lo = cmd.y_first;
                dec_hi = cmd.y_first;
            end
            mrde_pkg::OP_VLINE:
            begin
                dec_mid = mrde_pkg::span_mask(cmd.x_first, cmd.x_first);
                dec_end = mrde_pkg::span_mask(cmd.x_first, cmd.x_first);
            end
            mrde_pkg::OP_RECT:
            begin
                dec_paint = 1'b1;
            end
            mrde_pkg::OP_OUTLINE:
            begin
                dec_mid = mrde_pkg::span_mask(xl, xl) | mrde_pkg::span_mask(xh, xh);
            end
            default:
            begin
                dec_paint = 1'b0;
            end
        endcase
        dec_in      = (dec_lo <= TOP_ROW);
        dec_hi_clip = (dec_hi > TOP_ROW) ? TOP_ROW : dec_hi;
    end

    // Dirty range widening on accepted clear and drawing commands
    always_comb
    begin
        widen    = 1'b0;
        widen_lo = dec_lo;
        widen_hi = dec_hi_clip;
        if (cmd_fire && (cmd.opcode == mrde_pkg::OP_CLEAR))
        begin
            widen    = 1'b1;
            widen_lo = 5'd0;
            widen_hi = TOP_ROW;
        end
        else if (cmd_fire && dec_paint && dec_in)
        begin
            widen = 1'b1;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrde_pkg::ST_INIT, mrde_pkg::ST_FILL:
            begin
                if (fill_cnt_reg == FILL_LAST)
                begin
                    state_next = mrde_pkg::ST_IDLE;
                end
            end
            mrde_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    priority if (cmd.opcode == mrde_pkg::OP_CLEAR)
                    begin
                        state_next = mrde_pkg::ST_FILL;
                    end
                    else if (dec_paint && dec_in)
                    begin
                        state_next = mrde_pkg::ST_PAINT;
                    end
                    else if ((cmd.opcode == mrde_pkg::OP_FLUSH) && dirty_any_reg)
                    begin
                        state_next = mrde_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        state_next = mrde_pkg::ST_IDLE;
                    end
                end
            end
            mrde_pkg::ST_PAINT:
            begin
                if (paint_rd && (row_cnt_reg == row_end_reg))
                begin
                    state_next = mrde_pkg::ST_IDLE;
                end
            end
            mrde_pkg::ST_FLUSH:
            begin
                if (fl_issue && (fl_cnt_reg == fl_end_reg))
                begin
                    state_next = mrde_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mrde_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        cmd.ready = 1'b0;
        fill_wr   = 1'b0;
        paint_rd  = 1'b0;
        fl_issue  = 1'b0;
        unique case (state_reg)
            mrde_pkg::ST_INIT, mrde_pkg::ST_FILL:
            begin
                fill_wr = 1'b1;
            end
            mrde_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            mrde_pkg::ST_PAINT:
            begin
                paint_rd = !fp_valid_reg;
            end
            mrde_pkg::ST_FLUSH:
            begin
                fl_issue = !fp_valid_reg || !out_valid_reg || row.ready;
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    assign fp_adv = fp_valid_reg && (!out_valid_reg || row.ready);

    // Memory port steering
    assign wb_mask = ((wb_row_reg == yl_reg) || (wb_row_reg == yh_reg)) ? mask_end_reg
                                                                          : mask_mid_reg;

    always_comb
    begin
        mem_wr_en   = fill_wr || wb_valid_reg;
        mem_wr_addr = fill_wr ? fill_cnt_reg : wb_row_reg[AW-1:0];
        if (fill_wr)
        begin
            mem_wr_data = {mrde_pkg::ROW_W{fill_pen_reg}};
        end
        else if (pen_reg)
        begin
            mem_wr_data = mem_rd_data | wb_mask;
        end
        else
        begin
            mem_wr_data = mem_rd_data & ~wb_mask;
        end
        mem_rd_en   = paint_rd || fl_issue;
        mem_rd_addr = fl_issue ? fl_cnt_reg[AW-1:0] : row_cnt_reg[AW-1:0];
    end

    mrde_row_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_row_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mrde_pkg::ST_INIT;
            fill_cnt_reg    <= '0;
            fill_pen_reg    <= 1'b0;
            wb_valid_reg    <= 1'b0;
            fp_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            dirty_any_reg   <= 1'b0;
            dirty_first_reg <= '0;
            dirty_last_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            wb_valid_reg <= paint_rd;

            if (fill_wr)
            begin
                fill_cnt_reg <= (fill_cnt_reg == FILL_LAST) ? '0 : fill_cnt_reg + 1'b1;
            end
            if (cmd_fire && (cmd.opcode == mrde_pkg::OP_CLEAR))
            begin
                fill_pen_reg <= cmd.pen_color;
            end

            if (fl_issue)
            begin
                fp_valid_reg <= 1'b1;
            end
            else if (fp_adv)
            begin
                fp_valid_reg <= 1'b0;
            end

            if (fp_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (row.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd_fire && (cmd.opcode == mrde_pkg::OP_FLUSH))
            begin
                dirty_any_reg <= 1'b0;
            end
            else if (widen)
            begin
                dirty_any_reg <= 1'b1;
                if (!dirty_any_reg || (widen_lo < dirty_first_reg))
                begin
                    dirty_first_reg <= widen_lo;
                end
                if (!dirty_any_reg || (widen_hi > dirty_last_reg))
                begin
                    dirty_last_reg <= widen_hi;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            row_cnt_reg  <= dec_lo;
            row_end_reg  <= dec_hi_clip;
            yl_reg       <= dec_lo;
            yh_reg       <= dec_hi;
            mask_mid_reg <= dec_mid;
            mask_end_reg <= dec_end;
            pen_reg      <= cmd.pen_color;
            fl_cnt_reg   <= dirty_first_reg;
            fl_end_reg   <= dirty_last_reg;
        end
        else
        begin
            if (paint_rd)
            begin
                row_cnt_reg <= row_cnt_reg + 5'd1;
            end
            if (fl_issue)
            begin
                fl_cnt_reg <= fl_cnt_reg + 5'd1;
            end
        end
        if (paint_rd)
        begin
            wb_row_reg <= row_cnt_reg;
        end
        if (fl_issue)
        begin
            fp_row_reg  <= fl_cnt_reg;
            fp_last_reg <= (fl_cnt_reg == fl_end_reg);
        end
        if (fp_adv)
        begin
            out_index_reg  <= fp_row_reg;
            out_last_reg   <= fp_last_reg;
            out_pixels_reg <= mem_rd_data;
        end
    end

    assign row.valid      = out_valid_reg;
    assign row.row_index  = out_index_reg;
    assign row.row_pixels = out_pixels_reg;
    assign row.last_row   = out_last_reg;

endmodule

>>> hw/rtl/mrde_checker.sv
// Port-level checks of the draw engine flush stream, bound to the top level.
`include "mono_raster_draw_engine_macros.svh"

module mrde_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        row_valid,
    input logic        row_ready,
    input logic [4:0]  row_index,
    input logic [31:0] row_pixels,
    input logic        row_last
);

    `MRDE_ASSERT_IMPLY(a_row_hold, clk, rst_n, $past(row_valid && !row_ready), row_valid && $stable(row_index) && $stable(row_pixels) && $stable(row_last), "stalled row request changed")
    `MRDE_ASSERT_NEXT(a_row_burst, clk, rst_n, row_valid && row_ready && !row_last, row_valid, "gap inside a flush burst")
    `MRDE_ASSERT_NEXT(a_row_order, clk, rst_n, row_valid && row_ready && !row_last, row_index == $past(row_index) + 5'd1, "flushed rows out of order")

endmodule

bind mono_raster_draw_engine mrde_checker u_mrde_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .row_valid  (row.valid),
    .row_ready  (row.ready),
    .row_index  (row.row_index),
    .row_pixels (row.row_pixels),
    .row_last   (row.last_row)
);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the monochrome draw engine: drawing and flush requests.
module tb;

    localparam int ROWS = 32;
    localparam int STORE_ROWS = (ROWS < mrde_pkg::ADDR_ROWS) ? ROWS : mrde_pkg::ADDR_ROWS;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int RANDOM_CMDS = 280;
    localparam int SETTLE_CYCLES = 48;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [2:0] opcode;
        logic [4:0] x_first;
        logic [4:0] y_first;
        logic [4:0] x_second;
        logic [4:0] y_second;
        logic       pen_color;
    } draw_cmd_t;

    typedef struct packed {
        logic [4:0]  row_index;
        logic [31:0] row_pixels;
        logic        last_row;
    } flushed_row_t;

    logic clk;
    logic rst_n;

    mrde_cmd_if cmd();
    mrde_row_if row();

    mono_raster_draw_engine #(.ROWS(ROWS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .row(row)
    );

    logic [31:0]  shadow_rows [mrde_pkg::ADDR_ROWS];
    int           dirty_lo;
    int           dirty_hi;
    flushed_row_t pending_rows [$];
    flushed_row_t want_row;
    int           err_count = 0;
    longint       cycle_count = 0;
    bit           no_idle = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[mono_raster_draw_engine] ERROR");
            $finish;
        end
    end

    // ---- frame store prediction ----

    function automatic logic [31:0] column_span(logic [4:0] a, logic [4:0] b);
        logic [31:0] m;
        m = '0;
        for (int c = int'(a); c <= int'(b); c++)
            m[31 - c] = 1'b1;
        return m;
    endfunction

    function automatic void paint_shadow(int r, logic [31:0] mask, logic pen);
        if (r < 0 || r >= STORE_ROWS)
            return;
        if (pen)
            shadow_rows[r] = shadow_rows[r] | mask;
        else
            shadow_rows[r] = shadow_rows[r] & ~mask;
    endfunction

    function automatic void paint_shadow_range(int lo, int hi, logic [31:0] mask, logic pen);
        for (int r = lo; r <= hi; r++)
            paint_shadow(r, mask, pen);
    endfunction

    function automatic void grow_shadow_dirty(int lo, int hi);
        int top;
        top = STORE_ROWS - 1;
        if (lo > top)
            return;
        if (hi > top)
            hi = top;
        if (lo < dirty_lo)
            dirty_lo = lo;
        if (hi > dirty_hi)
            dirty_hi = hi;
    endfunction

    function automatic void reset_shadow();
        for (int r = 0; r < mrde_pkg::ADDR_ROWS; r++)
            shadow_rows[r] = '0;
        dirty_lo = mrde_pkg::ADDR_ROWS;
        dirty_hi = -1;
    endfunction

    function automatic void predict_command(draw_cmd_t c);
        logic [4:0]   xl;
        logic [4:0]   xh;
        int           y1;
        int           yl;
        int           yh;
        int           n;
        flushed_row_t fr;
        xl = (c.x_first < c.x_second) ? c.x_first : c.x_second;
        xh = (c.x_first < c.x_second) ? c.x_second : c.x_first;
        y1 = int'(c.y_first);
        yl = (c.y_first < c.y_second) ? int'(c.y_first) : int'(c.y_second);
        yh = (c.y_first < c.y_second) ? int'(c.y_second) : int'(c.y_first);
        unique case (c.opcode)
            mrde_pkg::OP_CLEAR:
            begin
                paint_shadow_range(0, STORE_ROWS - 1, '1, c.pen_color);
                grow_shadow_dirty(0, mrde_pkg::ADDR_ROWS - 1);
            end
            mrde_pkg::OP_PIXEL:
            begin
                paint_shadow(y1, column_span(c.x_first, c.x_first), c.pen_color);
                grow_shadow_dirty(y1, y1);
            end
            mrde_pkg::OP_HLINE:
            begin
                paint_shadow(y1, column_span(xl, xh), c.pen_color);
                grow_shadow_dirty(y1, y1);
            end
            mrde_pkg::OP_VLINE:
            begin
                paint_shadow_range(yl, yh, column_span(c.x_first, c.x_first), c.pen_color);
                grow_shadow_dirty(yl, yh);
            end
            mrde_pkg::OP_RECT:
            begin
                paint_shadow_range(yl, yh, column_span(xl, xh), c.pen_color);
                grow_shadow_dirty(yl, yh);
            end
            mrde_pkg::OP_OUTLINE:
            begin
                paint_shadow(yl, column_span(xl, xh), c.pen_color);
                paint_shadow(yh, column_span(xl, xh), c.pen_color);
                paint_shadow_range(yl, yh, column_span(xl, xl) | column_span(xh, xh),
                                   c.pen_color);
                grow_shadow_dirty(yl, yh);
            end
            mrde_pkg::OP_FLUSH:
            begin
                n = 0;
                for (int r = dirty_lo; r <= dirty_hi && n < mrde_pkg::ADDR_ROWS; r++)
                begin
                    fr.row_index  = r[4:0];
                    fr.row_pixels = (r >= 0 && r < STORE_ROWS) ? shadow_rows[r] : '0;
                    fr.last_row   = (r == dirty_hi);
                    pending_rows.push_back(fr);
                    n++;
                end
                dirty_lo = mrde_pkg::ADDR_ROWS;
                dirty_hi = -1;
            end
            default:
            begin
            end
        endcase
    endfunction

    // ---- result checking ----

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, want %h (cycle %0d)", what, got, want, cycle_count);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && row.valid && row.ready)
        begin
            if (pending_rows.size() == 0)
                report_mismatch("unexpected row", {27'd0, row.row_index}, 32'd0);
            else
            begin
                want_row = pending_rows.pop_front();
                if (row.row_index !== want_row.row_index)
                    report_mismatch("row_index", {27'd0, row.row_index},
                                    {27'd0, want_row.row_index});
                if (row.row_pixels !== want_row.row_pixels)
                    report_mismatch("row_pixels", row.row_pixels, want_row.row_pixels);
                if (row.last_row !== want_row.last_row)
                    report_mismatch("last_row", {31'd0, row.last_row},
                                    {31'd0, want_row.last_row});
            end
        end
    end

    // ---- stimulus helpers ----

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial
    begin
        int n;
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                row.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            row.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    function automatic draw_cmd_t mk_cmd(logic [2:0] op, logic [4:0] x1, logic [4:0] y1,
                                         logic [4:0] x2, logic [4:0] y2, logic pen);
        draw_cmd_t c;
        c.opcode    = op;
        c.x_first   = x1;
        c.y_first   = y1;
        c.x_second  = x2;
        c.y_second  = y2;
        c.pen_color = pen;
        return c;
    endfunction

    function automatic logic [4:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 5'd0;
        if (r == 1)
            return 5'd31;
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic draw_cmd_t rand_cmd();
        int         r;
        logic [2:0] op;
        r = $urandom_range(0, 99);
        if (r < 4)
            op = mrde_pkg::OP_CLEAR;
        else if (r < 20)
            op = mrde_pkg::OP_PIXEL;
        else if (r < 35)
            op = mrde_pkg::OP_HLINE;
        else if (r < 50)
            op = mrde_pkg::OP_VLINE;
        else if (r < 62)
            op = mrde_pkg::OP_RECT;
        else if (r < 74)
            op = mrde_pkg::OP_OUTLINE;
        else if (r < 96)
            op = mrde_pkg::OP_FLUSH;
        else
            op = OP_UNUSED;
        return mk_cmd(op, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      1'($urandom_range(0, 1)));
    endfunction

    task automatic send_cmd(input draw_cmd_t c);
        int gap;
        cmd.valid     <= 1'b1;
        cmd.opcode    <= c.opcode;
        cmd.x_first   <= c.x_first;
        cmd.y_first   <= c.y_first;
        cmd.x_second  <= c.x_second;
        cmd.y_second  <= c.y_second;
        cmd.pen_color <= c.pen_color;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        predict_command(c);
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        cmd.valid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---- tests ----

    task automatic test_empty_flush();
        send_cmd(mk_cmd(mrde_pkg::OP_FLUSH, 5'd31, 5'd31, 5'd31, 5'd31, 1'b1));
        send_cmd(mk_cmd(OP_UNUSED, 5'd0, 5'd0, 5'd0, 5'd0, 1'b0));
        wait_drained();
    endtask

    task automatic test_directed();
        send_cmd(mk_cmd(mrde_pkg::OP_CLEAR, 5'd0, 5'd0, 5'd0, 5'd0, 1'b1));
        send_cmd(mk_cmd(mrde_pkg::OP_FLUSH, 5'd0, 5'd0, 5'd0, 5'd0, 1'b0));
        send_cmd(mk_cmd(mrde_pkg::OP_CLEAR, 5'd31, 5'd31, 5'd31, 5'd31, 1'b0));
        send_cmd(mk_cmd(mrde_pkg::OP_PIXEL, 5'd0, 5'd0, 5'd31, 5'd31, 1'b1));
        send_cmd(mk_cmd(mrde_pkg::OP_PIXEL, 5'd31, 5'd31, 5'd0, 5'd0, 1'b1));
        send_cmd(mk_cmd(mrde_pkg::OP_PIXEL, 5'd31, 5'd0, 5'd0, 5'd31, 1'b1));
        send_cmd(mk_cmd(mrde_pkg::OP_HLINE, 5'd30, 5'd5, 5'd2, 5'd31, 1'b1));
        send_cmd(mk_cmd(mrde_pkg::OP_HLINE, 5'd17, 5'd6, 5'd17, 5'd0, 1'b1));
        send_cmd(mk_cmd(mrde_pkg::OP_VLINE, 5'd7, 5'd20, 5'd31, 5'd3, 1'b1));
        send_cmd(mk_cmd(mrde_pkg::OP_RECT, 5'd25, 5'd28, 5'd10, 5'd12, 1'b1));
        send_cmd(mk_cmd(mrde_pkg::OP_OUTLINE, 5'd31, 5'd31, 5'd0, 5'd0, 1'b1));
        send_cmd(mk_cmd(mrde_pkg::OP_OUTLINE, 5'd3, 5'd9, 5'd20, 5'd9, 1'b1));
        send_cmd(mk_cmd(mrde_pkg::OP_OUTLINE, 5'd14, 5'd2, 5'd14, 5'd25, 1'b1));
        send_cmd(mk_cmd(mrde_pkg::OP_FLUSH, 5'd31, 5'd0, 5'd31, 5'd0, 1'b1));
        wait_drained();
        send_cmd(mk_cmd(mrde_pkg::OP_CLEAR, 5'd0, 5'd0, 5'd0, 5'd0, 1'b1));
        send_cmd(mk_cmd(mrde_pkg::OP_RECT, 5'd20, 5'd30, 5'd4, 5'd1, 1'b0));
        send_cmd(mk_cmd(mrde_pkg::OP_HLINE, 5'd31, 5'd0, 5'd0, 5'd0, 1'b0));
        send_cmd(mk_cmd(mrde_pkg::OP_VLINE, 5'd31, 5'd31, 5'd0, 5'd0, 1'b0));
        send_cmd(mk_cmd(mrde_pkg::OP_OUTLINE, 5'd28, 5'd29, 5'd26, 5'd27, 1'b0));
        send_cmd(mk_cmd(mrde_pkg::OP_PIXEL, 5'd1, 5'd31, 5'd0, 5'd0, 1'b0));
        send_cmd(mk_cmd(OP_UNUSED, 5'd31, 5'd31, 5'd31, 5'd31, 1'b1));
        send_cmd(mk_cmd(mrde_pkg::OP_FLUSH, 5'd0, 5'd0, 5'd0, 5'd0, 1'b0));
        send_cmd(mk_cmd(mrde_pkg::OP_FLUSH, 5'd0, 5'd0, 5'd0, 5'd0, 1'b0));
        wait_drained();
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        for (int i = 0; i < 40; i++)
            send_cmd(rand_cmd());
        send_cmd(mk_cmd(mrde_pkg::OP_FLUSH, 5'd0, 5'd0, 5'd0, 5'd0, 1'b0));
        wait_drained();
        no_idle = 1'b0;
    endtask

    task automatic test_random();
        draw_cmd_t c;
        int        sent;
        sent = 0;
        while (sent < RANDOM_CMDS)
        begin
            c = rand_cmd();
            send_cmd(c);
            if (c.opcode != OP_UNUSED)
                sent++;
            if ($urandom_range(0, 59) == 0)
                wait_drained();
        end
        send_cmd(mk_cmd(mrde_pkg::OP_FLUSH, 5'd0, 5'd0, 5'd0, 5'd0, 1'b1));
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cmd.valid     <= 1'b0;
        cmd.opcode    <= mrde_pkg::OP_CLEAR;
        cmd.x_first   <= '0;
        cmd.y_first   <= '0;
        cmd.x_second  <= '0;
        cmd.y_second  <= '0;
        cmd.pen_color <= 1'b0;
        reset_shadow();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_flush();
        test_directed();
        test_back_to_back();
        test_random();
        wait_drained();

        if (err_count == 0)
            $display("[mono_raster_draw_engine] OK");
        else
            $display("[mono_raster_draw_engine] ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/mrde_pkg.sv
hw/rtl/mrde_cmd_if.sv
hw/rtl/mrde_row_if.sv
hw/rtl/mrde_row_mem.sv
hw/rtl/mono_raster_draw_engine.sv
hw/rtl/mrde_checker.sv
tb/sv/tb.sv
